// ===== src/c2s_pkg.sv =====
// ----------------------------------------------------------------------------
// c2s_pkg
// shared constants, types and the cordic arctangent table
// ----------------------------------------------------------------------------
package c2s_pkg;

  // cordic iterations, 8 to 24
  localparam int CORDIC_STAGES = 16;
  localparam int ATAN_LEN      = 24;

  // cordic operand width and internal datapath width
  localparam int OPW = 25;
  localparam int CW  = 44;

  // square root unit: radicand and root widths
  localparam int RADW  = 48;
  localparam int ROOTW = 24;

  localparam logic [31:0] HALF_TURN = 32'h8000_0000;
  localparam logic [31:0] ROUND_BIT = 32'h0000_8000;

  localparam logic [15:0] POL_HALF  = 16'd32768;
  localparam logic [15:0] POL_WRAP  = 16'd49152;

  // atan(2^-i) in units of 2^32 per turn
  localparam logic [31:0] ATAN_TABLE [ATAN_LEN] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  // point data carried alongside the square root pipeline
  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic               zero;
  } pt_t;

endpackage

// ===== src/c2s_if.sv =====
// ----------------------------------------------------------------------------
// c2s point and result channels
// valid/ready channels carrying one point or one spherical result per word
// ----------------------------------------------------------------------------
interface c2s_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] x_coord;
  logic signed [15:0] y_coord;
  logic signed [15:0] z_coord;

  modport source (output valid, output x_coord, output y_coord, output z_coord,
                  input ready);
  modport sink   (input valid, input x_coord, input y_coord, input z_coord,
                  output ready);
endinterface

interface c2s_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] radius;
  logic [15:0] azimuth;
  logic [15:0] polar_angle;
  logic        zero_vector;

  modport source (output valid, output radius, output azimuth, output polar_angle,
                  output zero_vector, input ready);
  modport sink   (input valid, input radius, input azimuth, input polar_angle,
                  input zero_vector, output ready);
endinterface

// ===== src/cartesian_to_spherical.sv =====
// throughput: one point per cycle; the whole pipeline advances together and
// holds while a finished result waits at the output register
// the pipeline is the 24-stage square root for the xy length followed by the cordic
// reset: synchronous, active high, clears all valid bits; data registers keep their values
// ----------------------------------------------------------------------------
// cartesian_to_spherical
// radius, azimuth and polar angle of a 16-bit cartesian point
// ----------------------------------------------------------------------------
module cartesian_to_spherical (
  input  logic             clk,
  input  logic             rst,
  c2s_in_if.sink           points,
  c2s_out_if.source        results
);

  localparam int N  = c2s_pkg::CORDIC_STAGES;
  localparam int SQ = c2s_pkg::ROOTW;
  localparam int L  = 3 + SQ + N;

  logic         en;
  logic [L-1:0] v;

  // stage 1 registers
  logic signed [15:0] x1, y1, z1;
  logic [30:0]        xx1, yy1, zz1;
  logic signed [31:0] xp, yp, zp;

  // stage 2 registers and delay line
  c2s_pkg::pt_t pd [SQ+1];
  logic [31:0]  sxy2, sum2;

  logic [c2s_pkg::ROOTW-1:0] rho, rsum;
  logic [31:0]               az_acc, pol_acc;
  logic signed [c2s_pkg::OPW-1:0] az_a, az_b, pol_a, pol_b;

  logic [15:0] rd [N+1];
  logic        zd [N+1];
  logic [15:0] az16, pol16, pol_fix;

  // global advance: move unless the output holds an unread word
  assign en           = !results.valid || results.ready;
  assign points.ready = en;

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[L-2:0], points.valid};
    end
  end

  // squares
  assign xp = points.x_coord * points.x_coord;
  assign yp = points.y_coord * points.y_coord;
  assign zp = points.z_coord * points.z_coord;

  always_ff @(posedge clk) begin
    if (en) begin
      x1  <= points.x_coord;
      y1  <= points.y_coord;
      z1  <= points.z_coord;
      xx1 <= xp[30:0];
      yy1 <= yp[30:0];
      zz1 <= zp[30:0];
    end
  end

  // sums of squares
  always_ff @(posedge clk) begin
    if (en) begin
      sxy2  <= {1'b0, xx1} + {1'b0, yy1};
      sum2  <= {1'b0, xx1} + {1'b0, yy1} + {1'b0, zz1};
      pd[0] <= '{x: x1, y: y1, z: z1, zero: (x1 == '0) && (y1 == '0) && (z1 == '0)};
    end
  end

  // point data follows the square root pipeline
  for (genvar k = 0; k < SQ; k++) begin : g_pdly
    always_ff @(posedge clk) begin
      if (en) begin
        pd[k+1] <= pd[k];
      end
    end
  end

  // xy length times 256, and full radius times 256
  c2s_isqrt u_sqrt_xy (
    .clk  (clk),
    .en   (en),
    .rad  ({sxy2, 16'd0}),
    .root (rho)
  );

  c2s_isqrt u_sqrt_r (
    .clk  (clk),
    .en   (en),
    .rad  ({sum2, 16'd0}),
    .root (rsum)
  );

  // cordic operands
  assign az_a  = {{(c2s_pkg::OPW-16){pd[SQ].x[15]}}, pd[SQ].x};
  assign az_b  = {{(c2s_pkg::OPW-16){pd[SQ].y[15]}}, pd[SQ].y};
  assign pol_a = {{(c2s_pkg::OPW-24){pd[SQ].z[15]}}, pd[SQ].z, 8'd0};
  assign pol_b = {{(c2s_pkg::OPW-c2s_pkg::ROOTW){1'b0}}, rho};

  c2s_cordic u_cordic_az (
    .clk   (clk),
    .en    (en),
    .a     (az_a),
    .b     (az_b),
    .angle (az_acc)
  );

  c2s_cordic u_cordic_pol (
    .clk   (clk),
    .en    (en),
    .a     (pol_a),
    .b     (pol_b),
    .angle (pol_acc)
  );

  // radius and zero flag follow the cordic
  assign rd[0] = rsum[c2s_pkg::ROOTW-1:8];
  assign zd[0] = pd[SQ].zero;

  for (genvar k = 0; k < N; k++) begin : g_rdly
    always_ff @(posedge clk) begin
      if (en) begin
        rd[k+1] <= rd[k];
        zd[k+1] <= zd[k];
      end
    end
  end

  // round to 16-bit binary angles and pull polar overshoot back into range
  always_comb begin
    az16  = 16'((az_acc + c2s_pkg::ROUND_BIT) >> 16);
    pol16 = 16'((pol_acc + c2s_pkg::ROUND_BIT) >> 16);
    if (pol16 > c2s_pkg::POL_WRAP) begin
      pol_fix = '0;
    end else if (pol16 > c2s_pkg::POL_HALF) begin
      pol_fix = c2s_pkg::POL_HALF;
    end else begin
      pol_fix = pol16;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (en) begin
      results.radius      <= zd[N] ? '0 : rd[N];
      results.azimuth     <= zd[N] ? '0 : az16;
      results.polar_angle <= zd[N] ? '0 : pol_fix;
      results.zero_vector <= zd[N];
    end
  end

  assign results.valid = v[L-1];

endmodule

// ===== src/c2s_isqrt.sv =====
// ----------------------------------------------------------------------------
// c2s_isqrt
// pipelined integer square root, one root bit per register stage
// ----------------------------------------------------------------------------
module c2s_isqrt (
  input  logic                         clk,
  input  logic                         en,
  input  logic [c2s_pkg::RADW-1:0]     rad,
  output logic [c2s_pkg::ROOTW-1:0]    root
);

  logic [c2s_pkg::RADW-1:0]  rem [c2s_pkg::ROOTW+1];
  logic [c2s_pkg::ROOTW-1:0] q   [c2s_pkg::ROOTW+1];

  assign rem[0] = rad;
  assign q[0]   = '0;

  // stage k decides root bit ROOTW-1-k
  for (genvar k = 0; k < c2s_pkg::ROOTW; k++) begin : g_stage
    localparam int I = c2s_pkg::ROOTW - 1 - k;
    logic [c2s_pkg::RADW-1:0] trial;
    logic                     ge;

    // root bits so far sit above the new bit, so the two terms never overlap
    assign trial = ({{(c2s_pkg::RADW-c2s_pkg::ROOTW){1'b0}}, q[k]} << (I + 1))
                 | ({{(c2s_pkg::RADW-1){1'b0}}, 1'b1} << (2 * I));
    assign ge    = rem[k] >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= ge ? rem[k] - trial : rem[k];
        q[k+1]   <= ge ? (q[k] | ({{(c2s_pkg::ROOTW-1){1'b0}}, 1'b1} << I)) : q[k];
      end
    end
  end

  assign root = q[c2s_pkg::ROOTW];

endmodule

// ===== src/c2s_cordic.sv =====
// ----------------------------------------------------------------------------
// c2s_cordic
// pipelined cordic vectoring, four-quadrant angle of (a, b) in 2^32 per turn
// ----------------------------------------------------------------------------
module c2s_cordic (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [c2s_pkg::OPW-1:0]   a,
  input  logic signed [c2s_pkg::OPW-1:0]   b,
  output logic [31:0]                      angle
);

  localparam int N = c2s_pkg::CORDIC_STAGES;
  localparam int CW = c2s_pkg::CW;

  logic signed [CW-1:0] px  [N+1];
  logic signed [CW-1:0] py  [N+1];
  logic [31:0]          acc [N+1];
  logic                 bz  [N+1];
  logic                 an  [N+1];

  logic signed [CW-1:0] a_sc;
  logic signed [CW-1:0] b_sc;

  // scale by 2^16 and fold the left half plane by half a turn
  assign a_sc   = {{(CW-c2s_pkg::OPW-16){a[c2s_pkg::OPW-1]}}, a, 16'd0};
  assign b_sc   = {{(CW-c2s_pkg::OPW-16){b[c2s_pkg::OPW-1]}}, b, 16'd0};
  assign px[0]  = a[c2s_pkg::OPW-1] ? -a_sc : a_sc;
  assign py[0]  = a[c2s_pkg::OPW-1] ? -b_sc : b_sc;
  assign acc[0] = a[c2s_pkg::OPW-1] ? c2s_pkg::HALF_TURN : '0;
  assign bz[0]  = (b == '0);
  assign an[0]  = a[c2s_pkg::OPW-1];

  for (genvar i = 0; i < N; i++) begin : g_iter
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic                 up;

    assign dx = py[i] >>> i;
    assign dy = px[i] >>> i;
    assign up = (py[i] > 0);

    // rotate toward the first axis
    always_ff @(posedge clk) begin
      if (en) begin
        px[i+1]  <= up ? px[i] + dx : px[i] - dx;
        py[i+1]  <= up ? py[i] - dy : py[i] + dy;
        acc[i+1] <= up ? acc[i] + c2s_pkg::ATAN_TABLE[i] : acc[i] - c2s_pkg::ATAN_TABLE[i];
        bz[i+1]  <= bz[i];
        an[i+1]  <= an[i];
      end
    end
  end

  // second operand zero: angle is exactly on the first axis
  assign angle = bz[N] ? (an[N] ? c2s_pkg::HALF_TURN : '0) : acc[N];

endmodule
